// ----- design/seir_pkg.sv -----
// ----------------------------------------------------------------------------
// seir_pkg - shared types, constants and helpers of the SEIR RK4 integrator
// Working values are signed, 16 fraction bits, saturating at +-(2^62-1).
// ----------------------------------------------------------------------------
package seir_pkg;

    localparam int COMP_W    = 40;   // compartment width, Q24.16
    localparam int FRAC_BITS = 16;
    localparam int RATE_W    = 24;   // rates and dt, Q4.20
    localparam int RATE_FRAC = 20;
    localparam int WORK_W    = 64;   // signed working value
    localparam int MAG_W     = 62;   // working magnitude
    localparam int ACC_W     = 124;  // full product of two magnitudes
    localparam int DEN_W     = 42;   // divisor width (sum of four compartments)
    localparam int SH_W      = 7;

    localparam logic [MAG_W-1:0]  MAG_MAX  = {MAG_W{1'b1}};
    localparam logic [COMP_W-1:0] COMP_MAX = {COMP_W{1'b1}};
    localparam logic [DEN_W-1:0]  N_ONE    = DEN_W'(1) << FRAC_BITS;

    // x/6 = (x * ceil(2^64/6)) >> 64, exact for any x below 2^62
    localparam logic [MAG_W-1:0]  RECIP_SIX = 62'h2AAA_AAAA_AAAA_AAAB;

    localparam logic [SH_W-1:0] SH_RATE = SH_W'(RATE_FRAC);
    localparam logic [SH_W-1:0] SH_HALF = SH_W'(RATE_FRAC + 1);
    localparam logic [SH_W-1:0] SH_SIX  = SH_W'(64);

    // configuration register indexes
    localparam logic [1:0] CFG_INFECTION  = 2'd0;
    localparam logic [1:0] CFG_INCUBATION = 2'd1;
    localparam logic [1:0] CFG_RECOVERY   = 2'd2;
    localparam logic [1:0] CFG_REMOVAL    = 2'd3;

    // input op codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef logic signed [WORK_W-1:0] work_t;
    typedef logic [MAG_W-1:0]         mag_t;

    // command to the multiply/divide unit
    typedef struct packed {
        logic             start;
        logic             muldiv;   // 1: a*b/divisor, 0: (a*b)>>sh
        mag_t             a;
        mag_t             b;
        logic [SH_W-1:0]  sh;
        logic [DEN_W-1:0] divisor;
    } mdu_cmd_t;

    typedef struct packed {
        logic done;
        mag_t result;
    } mdu_rsp_t;

    typedef enum logic [1:0] {
        MDU_IDLE,
        MDU_MUL,
        MDU_POST,
        MDU_DIV
    } mdu_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULXY,
        ST_RATE,
        ST_COMBINE,
        ST_ACCUM,
        ST_ADVANCE,
        ST_FIN_MUL,
        ST_FIN_DIV
    } step_state_t;

    // saturating add at +-(2^62-1)
    function automatic work_t sat_add(work_t a, work_t b);
        logic signed [WORK_W:0] s;
        logic signed [WORK_W:0] smax;
        s    = $signed({a[WORK_W-1], a}) + $signed({b[WORK_W-1], b});
        smax = $signed({3'b000, MAG_MAX});
        if (s > smax) begin
            s = smax;
        end
        else if (s < -smax) begin
            s = -smax;
        end
        return s[WORK_W-1:0];
    endfunction

    function automatic mag_t mag_of(work_t a);
        work_t t;
        t = a[WORK_W-1] ? -a : a;
        return t[MAG_W-1:0];
    endfunction

    function automatic work_t signed_of(mag_t m, logic neg);
        work_t t;
        t = $signed({2'b00, m});
        return neg ? -t : t;
    endfunction

endpackage

// ----- design/seir_rk4_step.sv -----
// ----------------------------------------------------------------------------
// seir_rk4_step - fixed-point SEIR integrator, one classic RK4 step per item
// Holds S, E, I, R (Q24.16) and advances them with rates beta, sigma, gamma,
// mu (Q4.20). All products and divisions go through one shared unit.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid / in_ready    | op, step_size, load_*
//  out     | output    | out_valid / out_ready  | *_out (four compartments)
//  cfg     | input     | cfg_write_en (no wait) | cfg_index, cfg_data
//
//  A load transaction posts its result in the cycle after acceptance. A step
//  runs 36 multiply jobs and 4 divisions by N on the single 32x32 multiply /
//  radix-4 divide unit, between which the sequencer combines derivatives and
//  accumulates the weighted sums. The block takes one transaction at a time;
//  in_ready is high only when idle and the result slot is empty or being
//  drained. Reset clears the compartments and rates.
// ----------------------------------------------------------------------------
module seir_rk4_step
    import seir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic [RATE_W-1:0] step_size,
    input  logic [COMP_W-1:0] load_susceptible,
    input  logic [COMP_W-1:0] load_exposed,
    input  logic [COMP_W-1:0] load_infectious,
    input  logic [COMP_W-1:0] load_recovered,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [COMP_W-1:0] susceptible_out,
    output logic [COMP_W-1:0] exposed_out,
    output logic [COMP_W-1:0] infectious_out,
    output logic [COMP_W-1:0] recovered_out,
    input  logic              cfg_write_en,
    input  logic [1:0]        cfg_index,
    input  logic [RATE_W-1:0] cfg_data
);

    step_state_t       st_reg, st_next;
    logic              wait_reg, wait_next;
    logic [1:0]        idx_reg, idx_next;
    logic [1:0]        stage_reg, stage_next;
    logic              out_valid_reg, out_valid_next;
    logic [COMP_W-1:0] comp_reg [4];
    logic [COMP_W-1:0] comp_next [4];
    logic [RATE_W-1:0] rate_reg [4];
    logic [RATE_W-1:0] rate_next [4];
    logic [RATE_W-1:0] dt_reg, dt_next;
    logic [DEN_W-1:0]  n_reg, n_next;
    work_t             z_reg [4];
    work_t             z_next [4];
    work_t             k_reg [4];
    work_t             k_next [4];
    work_t             t_reg [4];
    work_t             t_next [4];
    work_t             acca_reg [4];
    work_t             acca_next [4];
    work_t             accb_reg [4];
    work_t             accb_next [4];
    mag_t              fmag_reg, fmag_next;
    logic              fneg_reg, fneg_next;
    mdu_cmd_t          mdu_cmd;
    mdu_rsp_t          mdu_rsp;

    seir_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mdu_cmd),
        .rsp   (mdu_rsp)
    );

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            wait_reg      <= 1'b0;
            idx_reg       <= '0;
            stage_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                comp_reg[i] <= '0;
                rate_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg        <= st_next;
            wait_reg      <= wait_next;
            idx_reg       <= idx_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 4; i++)
            begin
                comp_reg[i] <= comp_next[i];
                rate_reg[i] <= rate_next[i];
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        dt_reg   <= dt_next;
        n_reg    <= n_next;
        fmag_reg <= fmag_next;
        fneg_reg <= fneg_next;
        for (int i = 0; i < 4; i++)
        begin
            z_reg[i]    <= z_next[i];
            k_reg[i]    <= k_next[i];
            t_reg[i]    <= t_next[i];
            acca_reg[i] <= acca_next[i];
            accb_reg[i] <= accb_next[i];
        end
    end

    assign in_ready        = (st_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid       = out_valid_reg;
    assign susceptible_out = comp_reg[0];
    assign exposed_out     = comp_reg[1];
    assign infectious_out  = comp_reg[2];
    assign recovered_out   = comp_reg[3];

    // sequencer
    always_comb
    begin
        logic [DEN_W-1:0] nsum;
        work_t            y;
        work_t            sum;
        work_t            v;
        work_t            kt;
        logic             sgn;

        st_next        = st_reg;
        wait_next      = wait_reg;
        idx_next       = idx_reg;
        stage_next     = stage_reg;
        out_valid_next = out_valid_reg;
        dt_next        = dt_reg;
        n_next         = n_reg;
        fmag_next      = fmag_reg;
        fneg_next      = fneg_reg;
        for (int i = 0; i < 4; i++)
        begin
            comp_next[i] = comp_reg[i];
            rate_next[i] = rate_reg[i];
            z_next[i]    = z_reg[i];
            k_next[i]    = k_reg[i];
            t_next[i]    = t_reg[i];
            acca_next[i] = acca_reg[i];
            accb_next[i] = accb_reg[i];
        end
        mdu_cmd         = '0;
        mdu_cmd.start   = !wait_reg;
        mdu_cmd.sh      = SH_RATE;
        mdu_cmd.divisor = n_reg;

        y   = $signed({{(WORK_W-COMP_W){1'b0}}, comp_reg[idx_reg]});
        sum = sat_add(acca_reg[idx_reg], accb_reg[idx_reg]);
        sgn = 1'b0;
        v   = '0;
        kt  = '0;

        nsum = {2'b00, comp_reg[0]} + {2'b00, comp_reg[1]}
             + {2'b00, comp_reg[2]} + {2'b00, comp_reg[3]};

        // result slot drains
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_INFECTION:  rate_next[0] = cfg_data;
                CFG_INCUBATION: rate_next[1] = cfg_data;
                CFG_RECOVERY:   rate_next[2] = cfg_data;
                CFG_REMOVAL:    rate_next[3] = cfg_data;
                default:        rate_next[0] = rate_reg[0];
            endcase
        end

        if (wait_reg && mdu_rsp.done)
        begin
            wait_next = 1'b0;
        end
        else if (!wait_reg && st_reg != ST_IDLE && st_reg != ST_COMBINE
                 && st_reg != ST_ACCUM)
        begin
            wait_next = 1'b1;
        end

        case (st_reg)
            ST_IDLE:
            begin
                mdu_cmd.start = 1'b0;
                if (in_valid && in_ready)
                begin
                    if (op == OP_LOAD)
                    begin
                        comp_next[0]   = load_susceptible;
                        comp_next[1]   = load_exposed;
                        comp_next[2]   = load_infectious;
                        comp_next[3]   = load_recovered;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        dt_next    = step_size;
                        n_next     = (nsum == '0) ? N_ONE : nsum;
                        stage_next = '0;
                        idx_next   = '0;
                        for (int i = 0; i < 4; i++)
                        begin
                            z_next[i] = $signed({{(WORK_W-COMP_W){1'b0}}, comp_reg[i]});
                        end
                        st_next = ST_MULXY;
                    end
                end
            end

            // S*I/N
            ST_MULXY:
            begin
                mdu_cmd.muldiv = 1'b1;
                mdu_cmd.a      = mag_of(z_reg[0]);
                mdu_cmd.b      = mag_of(z_reg[2]);
                if (wait_reg && mdu_rsp.done)
                begin
                    t_next[0] = signed_of(mdu_rsp.result, z_reg[0][WORK_W-1] ^ z_reg[2][WORK_W-1]);
                    idx_next  = '0;
                    st_next   = ST_RATE;
                end
            end

            // four rate products: inf, inc, rec, rem
            ST_RATE:
            begin
                case (idx_reg)
                    2'd0:
                    begin
                        mdu_cmd.a = mag_of(t_reg[0]);
                        sgn       = t_reg[0][WORK_W-1];
                    end
                    2'd1:
                    begin
                        mdu_cmd.a = mag_of(z_reg[1]);
                        sgn       = z_reg[1][WORK_W-1];
                    end
                    default:
                    begin
                        mdu_cmd.a = mag_of(z_reg[2]);
                        sgn       = z_reg[2][WORK_W-1];
                    end
                endcase
                mdu_cmd.b = {{(MAG_W-RATE_W){1'b0}}, rate_reg[idx_reg]};
                if (wait_reg && mdu_rsp.done)
                begin
                    t_next[idx_reg] = signed_of(mdu_rsp.result, sgn);
                    idx_next        = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        st_next = ST_COMBINE;
                    end
                end
            end

            // derivative of each compartment
            ST_COMBINE:
            begin
                mdu_cmd.start = 1'b0;
                k_next[0] = -t_reg[0];
                k_next[1] = sat_add(t_reg[0], -t_reg[1]);
                k_next[2] = sat_add(sat_add(t_reg[1], -t_reg[2]), -t_reg[3]);
                k_next[3] = t_reg[2];
                st_next   = ST_ACCUM;
            end

            // weighted sum kept as (k1 + 2k2) and (2k3 + k4)
            ST_ACCUM:
            begin
                mdu_cmd.start = 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    case (stage_reg)
                        2'd0:    acca_next[i] = k_reg[i];
                        2'd1:    acca_next[i] = sat_add(acca_reg[i],
                                                        sat_add(k_reg[i], k_reg[i]));
                        2'd2:    accb_next[i] = sat_add(k_reg[i], k_reg[i]);
                        default: accb_next[i] = sat_add(accb_reg[i], k_reg[i]);
                    endcase
                end
                idx_next = '0;
                st_next  = (stage_reg == 2'd3) ? ST_FIN_MUL : ST_ADVANCE;
            end

            // next evaluation point: y + k*dt/2 or y + k*dt
            ST_ADVANCE:
            begin
                kt        = k_reg[idx_reg];
                mdu_cmd.a = mag_of(kt);
                mdu_cmd.b = {{(MAG_W-RATE_W){1'b0}}, dt_reg};
                mdu_cmd.sh = (stage_reg == 2'd2) ? SH_RATE : SH_HALF;
                if (wait_reg && mdu_rsp.done)
                begin
                    z_next[idx_reg] = sat_add(y, signed_of(mdu_rsp.result, kt[WORK_W-1]));
                    idx_next        = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        stage_next = stage_reg + 2'd1;
                        st_next    = ST_MULXY;
                    end
                end
            end

            // dt * weighted sum
            ST_FIN_MUL:
            begin
                mdu_cmd.a = mag_of(sum);
                mdu_cmd.b = {{(MAG_W-RATE_W){1'b0}}, dt_reg};
                if (wait_reg && mdu_rsp.done)
                begin
                    fmag_next = mdu_rsp.result;
                    fneg_next = sum[WORK_W-1];
                    st_next   = ST_FIN_DIV;
                end
            end

            // divide by six through the reciprocal, add, clamp to the range
            ST_FIN_DIV:
            begin
                mdu_cmd.a  = fmag_reg;
                mdu_cmd.b  = RECIP_SIX;
                mdu_cmd.sh = SH_SIX;
                if (wait_reg && mdu_rsp.done)
                begin
                    v = sat_add(y, signed_of(mdu_rsp.result, fneg_reg));
                    if (v[WORK_W-1])
                    begin
                        comp_next[idx_reg] = '0;
                    end
                    else if (v[WORK_W-2:COMP_W] != '0)
                    begin
                        comp_next[idx_reg] = COMP_MAX;
                    end
                    else
                    begin
                        comp_next[idx_reg] = v[COMP_W-1:0];
                    end
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        out_valid_next = 1'b1;
                        st_next        = ST_IDLE;
                    end
                    else
                    begin
                        st_next = ST_FIN_MUL;
                    end
                end
            end

            default:
            begin
                mdu_cmd.start = 1'b0;
                st_next       = ST_IDLE;
            end
        endcase
    end

    // unit only answers a job that was issued
    assert property (@(posedge clk) disable iff (!rst_n)
        mdu_rsp.done |-> wait_reg)
        else $error("multiply/divide result without an outstanding job");

    // a step in progress always has a nonzero population
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> (n_reg != '0))
        else $error("population divisor is zero during a step");

    // no new transaction while a job is outstanding
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !wait_reg)
        else $error("input ready while the shared unit is busy");

    // a finished step leaves the sequencer idle with a result posted
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_FIN_DIV && st_next == ST_IDLE) |=> (out_valid && st_reg == ST_IDLE))
        else $error("step finished without posting a result");

endmodule

// ----- design/seir_mdu.sv -----
// ----------------------------------------------------------------------------
// seir_mdu - shared multiply / divide unit
// 62x62 product from four 32x32 partials, then either a right shift with
// saturation or a restoring division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module seir_mdu
    import seir_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mdu_cmd_t cmd,
    output mdu_rsp_t rsp
);

    mdu_state_t       st_reg, st_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             done_reg, done_next;
    mag_t             res_reg, res_next;
    mag_t             a_reg, a_next;
    mag_t             b_reg, b_next;
    logic [SH_W-1:0]  sh_reg, sh_next;
    logic             md_reg, md_next;
    logic [DEN_W-1:0] div_reg, div_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [DEN_W-1:0] rem_reg, rem_next;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= MDU_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        sh_reg  <= sh_next;
        md_reg  <= md_next;
        div_reg <= div_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        logic [31:0]      ach;
        logic [31:0]      bch;
        logic [63:0]      prod;
        logic [ACC_W-1:0] part;
        logic [1:0]       pos;
        logic [ACC_W-1:0] shifted;
        logic [DEN_W:0]   r1;
        logic [DEN_W-1:0] rem;
        logic [63:0]      low;

        st_next   = st_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        sh_next   = sh_reg;
        md_next   = md_reg;
        div_next  = div_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;

        // one partial product per cycle
        ach  = cnt_reg[1] ? {2'b00, a_reg[MAG_W-1:32]} : a_reg[31:0];
        bch  = cnt_reg[0] ? {2'b00, b_reg[MAG_W-1:32]} : b_reg[31:0];
        prod = 64'(ach) * 64'(bch);
        pos  = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
        case (pos)
            2'd0:    part = {60'b0, prod};
            2'd1:    part = {28'b0, prod, 32'b0};
            2'd2:    part = {prod[59:0], 64'b0};
            default: part = '0;
        endcase

        shifted = acc_reg >> sh_reg;

        // two restoring division steps
        rem = rem_reg;
        low = acc_reg[63:0];
        for (int i = 0; i < 2; i++)
        begin
            r1  = {rem, low[63]};
            low = {low[62:0], 1'b0};
            if (r1 >= {1'b0, div_reg})
            begin
                r1     = r1 - {1'b0, div_reg};
                low[0] = 1'b1;
            end
            rem = r1[DEN_W-1:0];
        end

        case (st_reg)
            MDU_IDLE:
            begin
                if (cmd.start)
                begin
                    a_next   = cmd.a;
                    b_next   = cmd.b;
                    sh_next  = cmd.sh;
                    md_next  = cmd.muldiv;
                    div_next = cmd.divisor;
                    acc_next = '0;
                    cnt_next = '0;
                    st_next  = MDU_MUL;
                end
            end
            MDU_MUL:
            begin
                acc_next = acc_reg + part;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    st_next = MDU_POST;
                end
            end
            MDU_POST:
            begin
                cnt_next = '0;
                if (!md_reg)
                begin
                    res_next  = (shifted[ACC_W-1:MAG_W] != '0) ? MAG_MAX
                                                              : shifted[MAG_W-1:0];
                    done_next = 1'b1;
                    st_next   = MDU_IDLE;
                end
                else if (acc_reg[ACC_W-1:64] >= {18'b0, div_reg})
                begin
                    // quotient would not fit in 64 bits
                    res_next  = MAG_MAX;
                    done_next = 1'b1;
                    st_next   = MDU_IDLE;
                end
                else
                begin
                    rem_next = acc_reg[64+DEN_W-1:64];
                    st_next  = MDU_DIV;
                end
            end
            MDU_DIV:
            begin
                rem_next        = rem;
                acc_next[63:0]  = low;
                cnt_next        = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    res_next  = (low[63:62] != 2'b00) ? MAG_MAX : low[MAG_W-1:0];
                    done_next = 1'b1;
                    st_next   = MDU_IDLE;
                end
            end
            default:
            begin
                st_next = MDU_IDLE;
            end
        endcase
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// ----- dv/tb_seir_rk4_step.sv -----
// ----------------------------------------------------------------------------
// tb_seir_rk4_step - self-checking bench for the SEIR RK4 integrator
// Drives load and step transactions with random gaps on both channels,
// predicts the four compartments after each transaction and compares them
// field by field, in order, with what the block returns.
// ----------------------------------------------------------------------------
module tb_seir_rk4_step;
    import seir_pkg::*;

    localparam logic [63:0] WMAX = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam int N_RANDOM = 930;

    typedef struct {
        logic [63:0] s, e, i, r;   // signed working values
    } quad_t;

    typedef struct {
        logic              op;
        logic [RATE_W-1:0] dt;
        logic [COMP_W-1:0] ls, le, li, lr;
    } stim_t;

    typedef struct {
        logic [COMP_W-1:0] s, e, i, r;
    } comp_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              op;
    logic [RATE_W-1:0] step_size;
    logic [COMP_W-1:0] load_susceptible, load_exposed, load_infectious, load_recovered;
    logic              out_valid;
    logic              out_ready;
    logic [COMP_W-1:0] susceptible_out, exposed_out, infectious_out, recovered_out;
    logic              cfg_write_en;
    logic [1:0]        cfg_index;
    logic [RATE_W-1:0] cfg_data;

    // predictor state
    logic [COMP_W-1:0] pop_s, pop_e, pop_i, pop_r;
    logic [RATE_W-1:0] beta, sigma, gamma_r, mu;

    comp_t compartments_due[$];
    int    error_count;

    seir_rk4_step u_dut (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ---------------- fixed-point arithmetic ----------------
    function automatic logic [63:0] magnitude(logic [63:0] a);
        return a[63] ? -a : a;
    endfunction

    function automatic logic [63:0] with_sign(logic [63:0] m, bit neg);
        if (m > WMAX) m = WMAX;
        return neg ? -m : m;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic signed [64:0] t;
        t = $signed({a[63], a}) + $signed({b[63], b});
        if (t > $signed({1'b0, WMAX})) t = {1'b0, WMAX};
        if (t < -$signed({1'b0, WMAX})) t = -$signed({1'b0, WMAX});
        return t[63:0];
    endfunction

    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] k, int sh);
        logic [127:0] p;
        p = (128'(magnitude(a)) * 128'(k)) >> sh;
        if (p[127:64] != 0) p = 128'(WMAX);
        return with_sign(p[63:0], a[63]);
    endfunction

    function automatic logic [63:0] mul_over(logic [63:0] x, logic [63:0] y,
                                            logic [63:0] den);
        logic [127:0] p, q;
        bit neg;
        neg = x[63] ^ y[63];
        p = 128'(magnitude(x)) * 128'(magnitude(y));
        if (p[127:64] >= den) return with_sign(WMAX, neg);
        q = p / den;
        return with_sign(q[63:0], neg);
    endfunction

    function automatic quad_t rates_of(quad_t y, logic [63:0] n);
        quad_t d;
        logic [63:0] inf, inc, rec, rmv;
        inf = mul_shift(mul_over(y.s, y.i, n), beta, RATE_FRAC);
        inc = mul_shift(y.e, sigma, RATE_FRAC);
        rec = mul_shift(y.i, gamma_r, RATE_FRAC);
        rmv = mul_shift(y.i, mu, RATE_FRAC);
        d.s = -inf;
        d.e = add_sat(inf, -inc);
        d.i = add_sat(add_sat(inc, -rec), -rmv);
        d.r = rec;
        return d;
    endfunction

    function automatic quad_t nudge(quad_t y, quad_t k, logic [63:0] dt, int sh);
        quad_t o;
        o.s = add_sat(y.s, mul_shift(k.s, dt, sh));
        o.e = add_sat(y.e, mul_shift(k.e, dt, sh));
        o.i = add_sat(y.i, mul_shift(k.i, dt, sh));
        o.r = add_sat(y.r, mul_shift(k.r, dt, sh));
        return o;
    endfunction

    function automatic logic [COMP_W-1:0] settle(logic [63:0] y, logic [63:0] k1,
            logic [63:0] k2, logic [63:0] k3, logic [63:0] k4, logic [63:0] dt);
        logic [63:0] sum, inc, v;
        sum = add_sat(add_sat(k1, add_sat(k2, k2)), add_sat(add_sat(k3, k3), k4));
        inc = mul_shift(sum, dt, RATE_FRAC);
        inc = with_sign(magnitude(inc) / 6, inc[63]);
        v = add_sat(y, inc);
        if (v[63]) return '0;
        if (v > 64'(COMP_MAX)) return COMP_MAX;
        return v[COMP_W-1:0];
    endfunction

    function automatic logic [63:0] widen(logic [COMP_W-1:0] v);
        return (64'(v) > WMAX) ? WMAX : 64'(v);
    endfunction

    // one RK4 step on the predicted compartments
    task automatic integrate(logic [RATE_W-1:0] dt_in);
        quad_t y, k1, k2, k3, k4;
        logic [63:0] n, dt;
        dt  = 64'(dt_in);
        y.s = widen(pop_s);
        y.e = widen(pop_e);
        y.i = widen(pop_i);
        y.r = widen(pop_r);
        n = add_sat(add_sat(y.s, y.e), add_sat(y.i, y.r));
        if (n == 0) n = 64'(1) << FRAC_BITS;
        k1 = rates_of(y, n);
        k2 = rates_of(nudge(y, k1, dt, RATE_FRAC + 1), n);
        k3 = rates_of(nudge(y, k2, dt, RATE_FRAC + 1), n);
        k4 = rates_of(nudge(y, k3, dt, RATE_FRAC), n);
        pop_s = settle(y.s, k1.s, k2.s, k3.s, k4.s, dt);
        pop_e = settle(y.e, k1.e, k2.e, k3.e, k4.e, dt);
        pop_i = settle(y.i, k1.i, k2.i, k3.i, k4.i, dt);
        pop_r = settle(y.r, k1.r, k2.r, k3.r, k4.r, dt);
    endtask

    task automatic predict_compartments(stim_t t);
        comp_t c;
        if (t.op == OP_LOAD) begin
            pop_s = t.ls;
            pop_e = t.le;
            pop_i = t.li;
            pop_r = t.lr;
        end
        else begin
            integrate(t.dt);
        end
        c.s = pop_s;
        c.e = pop_e;
        c.i = pop_i;
        c.r = pop_r;
        compartments_due.push_back(c);
    endtask

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk) begin
        comp_t c;
        if (rst_n && out_valid && out_ready) begin
            if (compartments_due.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(susceptible_out), 0);
            end
            else begin
                c = compartments_due.pop_front();
                if (susceptible_out !== c.s) report_mismatch("susceptible", susceptible_out, c.s);
                if (exposed_out !== c.e) report_mismatch("exposed", exposed_out, c.e);
                if (infectious_out !== c.i) report_mismatch("infectious", infectious_out, c.i);
                if (recovered_out !== c.r) report_mismatch("recovered", recovered_out, c.r);
            end
        end
    end

    // random stalls on the receive side
    always @(posedge clk) begin
        int w;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            w = $urandom_range(0, 99);
            if (w < 30) out_ready <= 1'b1;
            else if (w < 60) out_ready <= 1'b0;
            else if (w < 62) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(20, 400)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------
    // valid stays up between back-to-back transactions; drain lowers it
    task automatic send(stim_t t);
        int gap;
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 200) :
              ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        op               <= t.op;
        step_size        <= t.dt;
        load_susceptible <= t.ls;
        load_exposed     <= t.le;
        load_infectious  <= t.li;
        load_recovered   <= t.lr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_compartments(t);
    endtask

    task automatic write_rate(logic [1:0] idx, logic [RATE_W-1:0] v);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_INFECTION:  beta    = v;
            CFG_INCUBATION: sigma   = v;
            CFG_RECOVERY:   gamma_r = v;
            default:        mu      = v;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (compartments_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [RATE_W-1:0] rand_rate();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return RATE_W'($urandom_range(0, 1 << 24));
            default: return RATE_W'($urandom_range(0, 1 << 20)); // up to ~1.0
        endcase
    endfunction

    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COMP_MAX;
            2: return COMP_W'({$urandom(), $urandom()});
            default: return COMP_W'($urandom_range(0, 32'h7FFF_FFFF));
        endcase
    endfunction

    stim_t directed [] = '{
        '{OP_STEP, 24'h100000, 0, 0, 0, 0},               // zero population
        '{OP_LOAD, 0, 40'd65536000, 40'd65536, 40'd655360, 0},
        '{OP_STEP, 24'h000000, 0, 0, 0, 0},               // dt zero
        '{OP_STEP, 24'h019999, 0, 0, 0, 0},
        '{OP_STEP, 24'hFFFFFF, 0, 0, 0, 0},               // dt max
        '{OP_LOAD, 0, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
                      40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF},
        '{OP_STEP, 24'hFFFFFF, 0, 0, 0, 0},               // saturation
        '{OP_LOAD, 0, 40'hAA_AAAA_AAAA, 40'h55_5555_5555,
                      40'hAA_AAAA_AAAA, 40'h55_5555_5555},
        '{OP_STEP, 24'h0AAAAA, 0, 0, 0, 0},
        '{OP_LOAD, 0, 0, 0, 40'h1_0000, 0},
        '{OP_STEP, 24'hFFFFFF, 0, 0, 0, 0}                // negative clamp
    };

    initial begin
        stim_t t;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_LOAD;
        step_size = '0;
        load_susceptible = '0;
        load_exposed = '0;
        load_infectious = '0;
        load_recovered = '0;
        cfg_write_en = 1'b0;
        cfg_index = CFG_INFECTION;
        cfg_data = '0;
        pop_s = '0; pop_e = '0; pop_i = '0; pop_r = '0;
        beta = '0; sigma = '0; gamma_r = '0; mu = '0;
        error_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset every compartment reads zero
        t = '{OP_STEP, 24'h100000, 0, 0, 0, 0};
        send(t);
        drain();

        // directed table: run with moderate rates, then with all rates at maximum, then all zero
        for (int pass = 0; pass < 3; pass++) begin
            if (pass == 0) begin
                write_rate(CFG_INFECTION, 24'h080000);
                write_rate(CFG_INCUBATION, 24'h040000);
                write_rate(CFG_RECOVERY, 24'h020000);
                write_rate(CFG_REMOVAL, 24'h008000);
            end
            else begin
                for (int k = 0; k < 4; k++) write_rate(2'(k), pass == 1 ? '1 : '0);
            end
            foreach (directed[j]) send(directed[j]);
            drain();
        end

        // random phases with new rates between them
        for (int ph = 0; ph < 10; ph++) begin
            for (int k = 0; k < 4; k++) write_rate(2'(k), rand_rate());
            for (int j = 0; j < N_RANDOM / 10; j++) begin
                t.op = ($urandom_range(0, 3) == 0) ? OP_LOAD : OP_STEP;
                t.dt = rand_rate();
                t.ls = rand_comp();
                t.le = rand_comp();
                t.li = rand_comp();
                t.lr = rand_comp();
                send(t);
            end
            drain();
        end

        drain();
        if (error_count == 0) begin
            $display("tb_seir_rk4_step: PASS");
        end
        else begin
            $display("tb_seir_rk4_step: FAIL");
        end
        $finish;
    end

    // watchdog: ~1000 transactions plus gaps and stalls, many times over
    initial begin
        #(8 * 8000000);
        $display("tb_seir_rk4_step: FAIL");
        $finish;
    end

endmodule

// ----- seir_rk4_step.f -----
design/seir_pkg.sv
design/seir_mdu.sv
design/seir_rk4_step.sv
dv/tb_seir_rk4_step.sv
